>>> src/pip_pkg.sv
`default_nettype none

package pip_pkg;

  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountFull = 2'd3;

  typedef struct packed {
    logic restart;
    logic last;
    logic enough;
    logic test_open;
    logic test_close;
  } stage_flags_t;

endpackage

`default_nettype wire

>>> src/pip_edge_mul.sv
`default_nettype none

module pip_edge_mul #(
  parameter int DiffWidth = 25
) (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  signed [DiffWidth-1:0] ax_i,
  input  wire         [DiffWidth-1:0] am_i,
  input  wire  signed [DiffWidth-1:0] bx_i,
  input  wire         [DiffWidth-1:0] bn_i,
  output logic                        less_o
);

  localparam int ProdWidth = 2 * DiffWidth + 1;

  logic signed [ProdWidth-1:0] pa_d, pa_q;
  logic signed [ProdWidth-1:0] pb_d, pb_q;

  assign pa_d = ax_i * $signed({1'b0, am_i});
  assign pb_d = bx_i * $signed({1'b0, bn_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  assign less_o = pa_q < pb_q;

endmodule

`default_nettype wire

>>> src/point_in_polygon_test_core.sv
// Even-odd point-in-polygon test over a stream of polygon vertices.
// Input channel (in_valid_i / in_ready_o): one vertex per transaction, each
// carrying the query point and first/last marks. A vertex with no polygon
// open starts a new one as if it carried the first mark.
// Output channel (out_valid_o / out_ready_i): one transaction per polygon,
// given by the vertex marked last: inside_res_o and enough_vertices_o.
// Fewer than three vertices report enough_vertices_o 0 and inside_res_o 0.
// Throughput: one vertex per cycle while in_ready_o is high. A three-stage
// pipeline holds edge operands, then the two cross products per edge, then
// the result in the output register.
// When the receiver stalls with a result waiting, vertices that give no
// result still pass and update the parity; in_ready_o falls only when a
// second result would need the occupied output register.
// Reset clears the polygon state, the parity and the valid flags of the pipeline and the output register.
`default_nettype none

module point_in_polygon_test_core #(
  parameter int COORD_WIDTH = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [COORD_WIDTH-1:0] query_x_i,
  input  wire  signed [COORD_WIDTH-1:0] query_y_i,
  input  wire  signed [COORD_WIDTH-1:0] vertex_x_i,
  input  wire  signed [COORD_WIDTH-1:0] vertex_y_i,
  input  wire                          first_vertex_i,
  input  wire                          last_vertex_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         inside_res_o,
  output logic                         enough_vertices_o
);

  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] start_x_d, start_x_q, start_y_d, start_y_q;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic [1:0] count_d, count_q;

  logic v1_q, v2_q, parity_d, parity_q;
  logic out_valid_q, inside_q, enough_q;
  pip_pkg::stage_flags_t flags_d, flags1_q, flags2_q;

  logic signed [DW-1:0] oa_x_d, oa_x_q, ob_x_d, ob_x_q;
  logic signed [DW-1:0] ca_x_d, ca_x_q, cb_x_d, cb_x_q;
  logic [DW-1:0] oa_m_d, oa_m_q, ob_n_d, ob_n_q;
  logic [DW-1:0] ca_m_d, ca_m_q, cb_n_d, cb_n_q;

  logic out_free, adv2, ready2, adv1, in_fire;
  logic less_open, less_close, par_pre, par_post;

  function automatic logic signed [DW-1:0] sdiff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    sdiff = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
    mag = d[DW-1] ? (~d + 1'b1) : d;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv2       = v2_q && (!flags2_q.last || out_free);
  assign ready2     = !v2_q || adv2;
  assign adv1       = v1_q && ready2;
  assign in_ready_o = !v1_q || ready2;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    flags_d.restart = first_vertex_i || (count_q == pip_pkg::CountNone);
    flags_d.last    = last_vertex_i;
    start_x_d = flags_d.restart ? vertex_x_i : start_x_q;
    start_y_d = flags_d.restart ? vertex_y_i : start_y_q;
    if (flags_d.restart) begin
      count_d = pip_pkg::CountOne;
    end else if (count_q != pip_pkg::CountFull) begin
      count_d = count_q + 2'd1;
    end else begin
      count_d = count_q;
    end
    flags_d.enough     = count_d == pip_pkg::CountFull;
    flags_d.test_open  = !flags_d.restart &&
                         ((vertex_y_i > query_y_i) != (prev_y_q > query_y_i));
    flags_d.test_close = last_vertex_i &&
                         ((start_y_d > query_y_i) != (vertex_y_i > query_y_i));
    oa_x_d = sdiff(query_x_i, vertex_x_i);
    oa_m_d = mag(sdiff(prev_y_q, vertex_y_i));
    ob_x_d = sdiff(prev_x_q, vertex_x_i);
    ob_n_d = mag(sdiff(query_y_i, vertex_y_i));
    ca_x_d = sdiff(query_x_i, start_x_d);
    ca_m_d = mag(sdiff(vertex_y_i, start_y_d));
    cb_x_d = sdiff(vertex_x_i, start_x_d);
    cb_n_d = mag(sdiff(query_y_i, start_y_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      count_q   <= pip_pkg::CountNone;
    end else if (in_fire) begin
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      prev_x_q  <= vertex_x_i;
      prev_y_q  <= vertex_y_i;
      count_q   <= last_vertex_i ? pip_pkg::CountNone : count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      flags1_q <= flags_d;
      oa_x_q <= oa_x_d;
      oa_m_q <= oa_m_d;
      ob_x_q <= ob_x_d;
      ob_n_q <= ob_n_d;
      ca_x_q <= ca_x_d;
      ca_m_q <= ca_m_d;
      cb_x_q <= cb_x_d;
      cb_n_q <= cb_n_d;
    end
    if (adv1) begin
      flags2_q <= flags1_q;
    end
  end

  pip_edge_mul #(.DiffWidth(DW)) u_open_edge (
    .clk_i  (clk_i),
    .en_i   (adv1),
    .ax_i   (oa_x_q),
    .am_i   (oa_m_q),
    .bx_i   (ob_x_q),
    .bn_i   (ob_n_q),
    .less_o (less_open)
  );

  pip_edge_mul #(.DiffWidth(DW)) u_close_edge (
    .clk_i  (clk_i),
    .en_i   (adv1),
    .ax_i   (ca_x_q),
    .am_i   (ca_m_q),
    .bx_i   (cb_x_q),
    .bn_i   (cb_n_q),
    .less_o (less_close)
  );

  always_comb begin
    par_pre  = flags2_q.restart ? 1'b0 : parity_q;
    par_post = par_pre ^ (flags2_q.test_open && less_open)
                       ^ (flags2_q.test_close && less_close);
    parity_d = flags2_q.last ? 1'b0 : par_post;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= adv1;
      end
      if (adv2) begin
        parity_q <= parity_d;
      end
      if (adv2 && flags2_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && flags2_q.last) begin
      inside_q <= flags2_q.enough && par_post;
      enough_q <= flags2_q.enough;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign inside_res_o      = inside_q;
  assign enough_vertices_o = enough_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enough_vertices_o |-> !inside_res_o)
    else $error("inside reported without enough vertices");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled while output is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && flags2_q.last && !out_free |=> v2_q && flags2_q.last)
    else $error("pending result lost from final stage");
`endif

endmodule

`default_nettype wire

>>> test/tb_point_in_polygon_test_core.sv
`timescale 1ns / 100ps

module tb_point_in_polygon_test_core;

  localparam int CW = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  typedef struct {
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic                 first;
    logic                 last;
    int unsigned          gap;
  } vertex_item_t;

  typedef struct packed {
    logic in_poly;
    logic enough;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic inside_res_o;
  logic enough_vertices_o;

  vertex_item_t cur_item = '{default: 0};
  vertex_item_t pending[$];
  verdict_t     verdicts[$];

  longint signed poly_start_x = 0;
  longint signed poly_start_y = 0;
  longint signed poly_prev_x = 0;
  longint signed poly_prev_y = 0;
  logic          poly_parity = 1'b0;
  logic [1:0]    poly_count = pip_pkg::CountNone;

  int unsigned tx_hold = 0;
  int unsigned accepted_count = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_off = 0;
  bit          hold_off_done = 1'b0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  point_in_polygon_test_core #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .query_x_i        (cur_item.qx),
    .query_y_i        (cur_item.qy),
    .vertex_x_i       (cur_item.vx),
    .vertex_y_i       (cur_item.vy),
    .first_vertex_i   (cur_item.first),
    .last_vertex_i    (cur_item.last),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .inside_res_o     (inside_res_o),
    .enough_vertices_o(enough_vertices_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("point_in_polygon_test_core: mismatch");
      $finish;
    end
  end

  function automatic bit edge_crosses(input longint signed px, input longint signed py,
                                      input longint signed cx, input longint signed cy,
                                      input longint signed qx, input longint signed qy);
    longint signed span_y;
    longint signed reach_y;
    if ((cy > qy) == (py > qy)) return 1'b0;
    span_y = py - cy;
    if (span_y < 0) span_y = -span_y;
    reach_y = qy - cy;
    if (reach_y < 0) reach_y = -reach_y;
    return (qx - cx) * span_y < (px - cx) * reach_y;
  endfunction

  task automatic ray_cast_step(input vertex_item_t it);
    verdict_t v;
    if (it.first || poly_count == pip_pkg::CountNone) begin
      poly_start_x = it.vx;
      poly_start_y = it.vy;
      poly_parity = 1'b0;
      poly_count = pip_pkg::CountOne;
    end else begin
      if (edge_crosses(poly_prev_x, poly_prev_y, it.vx, it.vy, it.qx, it.qy))
        poly_parity = ~poly_parity;
      if (poly_count != pip_pkg::CountFull) poly_count = poly_count + 2'd1;
    end
    poly_prev_x = it.vx;
    poly_prev_y = it.vy;
    if (it.last) begin
      // close the polygon back to its first vertex
      if (edge_crosses(it.vx, it.vy, poly_start_x, poly_start_y, it.qx, it.qy))
        poly_parity = ~poly_parity;
      v.enough = (poly_count == pip_pkg::CountFull);
      v.in_poly = v.enough && poly_parity;
      verdicts = {verdicts, v};
      poly_count = pip_pkg::CountNone;
      poly_parity = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    vertex_item_t nxt;
    bit           free;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_hold <= 0;
    end else begin
      free = !in_valid;
      if (in_valid && in_ready_o) begin
        ray_cast_step(cur_item);
        accepted_count <= accepted_count + 1;
        free = 1'b1;
      end
      if (free) begin
        if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (tx_hold < pending[0].gap) begin
          tx_hold <= tx_hold + 1;
          in_valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          cur_item <= nxt;
          in_valid <= 1'b1;
          tx_hold <= 0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    verdict_t    want;
    int unsigned n;
    int unsigned bad;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      hold_off <= 0;
      hold_off_done <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        bad = 0;
        results_seen <= results_seen + 1;
        if (verdicts.size() == 0) begin
          $display("%0t: expected no result, actual inside_res %0b enough_vertices %0b",
                   $time, inside_res_o, enough_vertices_o);
          bad = bad + 1;
        end else begin
          want = verdicts.pop_front();
          if (inside_res_o !== want.in_poly) begin
            $display("%0t: inside_res expected %0b actual %0b",
                     $time, want.in_poly, inside_res_o);
            bad = bad + 1;
          end
          if (enough_vertices_o !== want.enough) begin
            $display("%0t: enough_vertices expected %0b actual %0b",
                     $time, want.enough, enough_vertices_o);
            bad = bad + 1;
          end
        end
        mismatches <= mismatches + bad;
      end
      if (!hold_off_done && accepted_count >= 60) begin
        // hold off long enough for the block to back up into its input
        hold_off <= HOLD_OFF_CYCLES;
        hold_off_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_ready <= (hold_off == 1);
      end else if (out_valid_o && out_ready) begin
        n = ((results_seen / 24) % 3 == 0) ? 0 : $urandom_range(0, 18);
        rx_wait <= n;
        out_ready <= (n == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_vertex(input int qx, input int qy, input int vx, input int vy,
                            input bit first, input bit last);
    vertex_item_t it;
    it.qx = qx[CW-1:0];
    it.qy = qy[CW-1:0];
    it.vx = vx[CW-1:0];
    it.vy = vy[CW-1:0];
    it.first = first;
    it.last = last;
    if (calm || (pending.size() >= 50 && pending.size() < 130)) it.gap = 0;
    else it.gap = $urandom_range(0, 18);
    pending = {pending, it};
  endtask

  function automatic int pick_coord(input int unsigned style);
    int          v;
    int unsigned k;
    case (style)
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 16)) - 8;
      2: v = int'($urandom_range(0, 2000)) - 1000;
      default: begin
        k = $urandom_range(0, 5);
        case (k)
          0: v = -8388608;
          1: v = 8388607;
          2: v = 0;
          3: v = -1;
          default: v = int'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_random_polygon();
    int unsigned kind;
    int unsigned nv;
    int unsigned style;
    int          qx;
    int          qy;
    int          vx;
    int          vy;
    bit          first;
    kind = $urandom_range(0, 9);
    if (kind == 0) nv = $urandom_range(1, 2);
    else if (kind == 1) nv = $urandom_range(9, 24);
    else nv = $urandom_range(3, 8);
    style = $urandom_range(0, 3);
    qx = pick_coord(style);
    qy = pick_coord(style);
    for (int unsigned i = 0; i < nv; i++) begin
      vx = pick_coord(style);
      vy = ($urandom_range(0, 5) == 0) ? qy : pick_coord(style);
      if ($urandom_range(0, 9) == 0) begin
        qx = pick_coord(style);
        qy = pick_coord(style);
      end
      if (i == 0) first = ($urandom_range(0, 5) != 0);
      else first = ($urandom_range(0, 29) == 0);
      add_vertex(qx, qy, vx, vy, first, i == nv - 1);
    end
  endtask

  initial begin
    // triangle opened without a first mark straight after reset
    add_vertex(0, 0, -10, -10, 0, 0);
    add_vertex(0, 0, 10, -10, 0, 0);
    add_vertex(0, 0, 0, 10, 0, 1);
    // square, query to the right
    add_vertex(200, 0, -100, -100, 1, 0);
    add_vertex(200, 0, 100, -100, 0, 0);
    add_vertex(200, 0, 100, 100, 0, 0);
    add_vertex(200, 0, -100, 100, 0, 1);
    // square, query level with the bottom edge
    add_vertex(0, -100, -100, -100, 1, 0);
    add_vertex(0, -100, 100, -100, 0, 0);
    add_vertex(0, -100, 100, 100, 0, 0);
    add_vertex(0, -100, -100, 100, 0, 1);
    // single vertex, then two vertices
    add_vertex(5, 5, 1, 1, 1, 1);
    add_vertex(0, 0, -5, -5, 1, 0);
    add_vertex(0, 0, 5, 5, 0, 1);
    // full-scale triangle, query moving on every vertex
    add_vertex(-8388608, 8388607, -8388608, -8388608, 1, 0);
    add_vertex(0, 0, 8388607, -8388608, 0, 0);
    add_vertex(8388607, -8388608, 0, 8388607, 0, 1);
    // restart in the middle of a polygon
    add_vertex(0, 0, 100, 100, 1, 0);
    add_vertex(0, 0, -100, -100, 1, 0);
    add_vertex(0, 0, 100, -100, 0, 0);
    add_vertex(0, 0, 0, 100, 0, 1);
    while (pending.size() < 1150) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      add_random_polygon();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid) @(posedge clk_i);
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("point_in_polygon_test_core: match");
    end else begin
      $display("point_in_polygon_test_core: mismatch");
    end
    $finish;
  end

endmodule

>>> point_in_polygon_test_core.f
src/pip_pkg.sv
src/pip_edge_mul.sv
src/point_in_polygon_test_core.sv
test/tb_point_in_polygon_test_core.sv
